FILE: hw/rtl/assert_macros.svh
// Shared assertion forms for the list engine checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, silent while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, silent while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/sle_pkg.sv
package sle_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 9;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_GET    = 3'd0,
    FN_LOCATE = 3'd1,
    FN_PRIOR  = 3'd2,
    FN_NEXT   = 3'd3,
    FN_INSERT = 3'd4,
    FN_DELETE = 3'd5,
    FN_CLEAR  = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          pos_idx;
    logic [IDX_W-1:0]          last_idx;
    logic signed [DATA_W-1:0]  value;
  } chain_ctl_t;

endpackage

FILE: hw/rtl/sle_cell.sv
module sle_cell import sle_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         cell_idx,
  input  chain_ctl_t               ctl,
  input  logic signed [DATA_W-1:0] left_word,
  input  logic signed [DATA_W-1:0] right_word,
  input  logic signed [DATA_W-1:0] head_word,
  output logic signed [DATA_W-1:0] word
);

  logic signed [DATA_W-1:0] word_r;
  logic signed [DATA_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (cell_idx == ctl.pos_idx) begin
          word_nxt = ctl.value;
        end else if (cell_idx > ctl.pos_idx) begin
          word_nxt = left_word;
        end
      end
      CELL_DELETE: begin
        if (cell_idx >= ctl.pos_idx) begin
          word_nxt = right_word;
        end
      end
      CELL_ROTATE: begin
        // the head word wraps round to the last occupied cell
        if (cell_idx == ctl.last_idx) begin
          word_nxt = head_word;
        end else if (cell_idx < ctl.last_idx) begin
          word_nxt = right_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

FILE: hw/rtl/sle_chain.sv
module sle_chain import sle_pkg::*; (
  input  logic                     clk,
  input  chain_ctl_t               ctl,
  output logic signed [DATA_W-1:0] head_word
);

  logic signed [DATA_W-1:0] words [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    sle_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (words[0]),
      .word       (words[i])
    );
  end

  assign head_word = words[0];

endmodule

FILE: hw/rtl/sle_ctrl.sv
module sle_ctrl import sle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic [POS_W-1:0]         out_found_position,
  output logic [POS_W-1:0]         out_count,
  output logic                     out_empty_res,
  output chain_ctl_t               chain_ctl,
  input  logic signed [DATA_W-1:0] head_word
);

  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [IDX_W-1:0]         step_r, step_nxt;
  logic [IDX_W-1:0]         pidx_r, pidx_nxt;
  func_t                    op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  status_t                  status_r, status_nxt;
  logic [POS_W-1:0]         fpos_r, fpos_nxt;
  logic                     found_r, found_nxt;
  logic                     want_r, want_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [POS_W-1:0]         out_fpos_r, out_fpos_nxt;
  logic [POS_W-1:0]         out_count_r, out_count_nxt;
  logic                     out_empty_r, out_empty_nxt;

  func_t                    in_op;
  logic                     out_room;
  logic                     accept;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         fill_c;
  logic                     pos_in_list;
  logic                     pos_for_ins;
  logic [IDX_W-1:0]         pos_m1;
  logic [IDX_W-1:0]         last_idx;
  logic                     load;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_data;
  logic [POS_W-1:0]         res_fpos;

  assign in_op       = func_t'(in_func);
  assign out_room    = !out_valid_r || !out_stall;
  assign in_stall    = !((state_r == S_IDLE) && out_room);
  assign accept      = in_valid && !in_stall;
  assign pos_c       = CMP_W'(in_position);
  assign fill_c      = CMP_W'(fill_r);
  assign pos_in_list = (pos_c != '0) && (pos_c <= fill_c);
  assign pos_for_ins = (pos_c != '0) && (pos_c <= fill_c + CMP_W'(1));
  assign pos_m1      = IDX_W'(in_position - POS_W'(1));
  assign last_idx    = IDX_W'(fill_r - CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    step_nxt   = step_r;
    pidx_nxt   = pidx_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    prev_nxt   = prev_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    fpos_nxt   = fpos_r;
    found_nxt  = found_r;
    want_nxt   = want_r;

    load       = 1'b0;
    res_status = status_r;
    res_data   = data_r;
    res_fpos   = fpos_r;

    chain_ctl.op       = CELL_HOLD;
    chain_ctl.pos_idx  = pos_m1;
    chain_ctl.last_idx = last_idx;
    chain_ctl.value    = in_value;

    unique case (state_r)
      S_IDLE: begin
        res_status = ST_OK;
        res_data   = '0;
        res_fpos   = '0;
        if (accept) begin
          op_nxt     = in_op;
          val_nxt    = in_value;
          pidx_nxt   = pos_m1;
          step_nxt   = '0;
          prev_nxt   = '0;
          data_nxt   = '0;
          fpos_nxt   = '0;
          found_nxt  = 1'b0;
          want_nxt   = 1'b0;
          status_nxt = ST_OK;
          unique case (in_op) inside
            FN_GET, FN_DELETE: begin
              if (pos_in_list) begin
                state_nxt = S_SCAN;
              end else begin
                load       = 1'b1;
                res_status = ST_BADPOS;
              end
            end
            FN_LOCATE, FN_PRIOR, FN_NEXT: begin
              status_nxt = ST_NOTFOUND;
              if (fill_r != '0) begin
                state_nxt = S_SCAN;
              end else begin
                load       = 1'b1;
                res_status = ST_NOTFOUND;
              end
            end
            FN_INSERT: begin
              load = 1'b1;
              if (!pos_for_ins) begin
                res_status = ST_BADPOS;
              end else if (fill_r == CNT_W'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                chain_ctl.op = CELL_INSERT;
                fill_nxt     = fill_r + CNT_W'(1);
              end
            end
            FN_CLEAR: begin
              load     = 1'b1;
              fill_nxt = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // rotate the occupied prefix once; the head shows element step_r
        chain_ctl.op = CELL_ROTATE;
        prev_nxt     = head_word;
        step_nxt     = step_r + IDX_W'(1);
        unique case (op_r) inside
          FN_GET, FN_DELETE: begin
            if (step_r == pidx_r) begin
              data_nxt = head_word;
            end
          end
          FN_LOCATE, FN_PRIOR, FN_NEXT: begin
            if (want_r) begin
              data_nxt   = head_word;
              status_nxt = ST_OK;
              want_nxt   = 1'b0;
            end
            if (!found_r && (head_word == val_r)) begin
              found_nxt = 1'b1;
              fpos_nxt  = POS_W'(step_r) + POS_W'(1);
              if (op_r == FN_LOCATE) begin
                status_nxt = ST_OK;
              end else if (op_r == FN_PRIOR) begin
                if (step_r != '0) begin
                  data_nxt   = prev_r;
                  status_nxt = ST_OK;
                end
              end else begin
                // successor arrives at the head on the next step, if any
                want_nxt = 1'b1;
              end
            end
          end
          default: begin
            data_nxt = data_r;
          end
        endcase
        if (step_r == last_idx) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_room) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          if (op_r == FN_DELETE) begin
            chain_ctl.op      = CELL_DELETE;
            chain_ctl.pos_idx = pidx_r;
            fill_nxt          = fill_r - CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_fpos_nxt   = out_fpos_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_data_nxt   = res_data;
      out_fpos_nxt   = res_fpos;
      out_count_nxt  = POS_W'(fill_nxt);
      out_empty_nxt  = (fill_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    pidx_r       <= pidx_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    prev_r       <= prev_nxt;
    data_r       <= data_nxt;
    status_r     <= status_nxt;
    fpos_r       <= fpos_nxt;
    found_r      <= found_nxt;
    want_r       <= want_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data           = out_data_r;
  assign out_found_position = out_fpos_r;
  assign out_count          = out_count_r;
  assign out_empty_res      = out_empty_r;

endmodule

FILE: hw/rtl/sequential_list_engine_core.sv
// Ordered list of up to 256 signed 32-bit words, kept in a row of cells with
// cell 0 at the head. Insert, clear, the unused code and every request that is
// refused outright (bad position, full list, locate, prior or next on an empty
// list) finish in the cycle they are taken and the result is offered on the
// next. Get, locate, prior, next and delete rotate the occupied part of the row
// once past the head comparator, one element per cycle, then wait in a finish
// state until the result register has room; delete fetches the word during the
// rotation and closes the gap in the same cycle that loads its result. One
// request is in flight at a time. A new request is taken whenever the engine is
// idle and the result register is free or being emptied in the same cycle.
module sequential_list_engine_core import sle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic [POS_W-1:0]         out_found_position,
  output logic [POS_W-1:0]         out_count,
  output logic                     out_empty_res
);

  chain_ctl_t               chain_ctl;
  logic signed [DATA_W-1:0] head_word;

  sle_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_data           (out_data),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_empty_res      (out_empty_res),
    .chain_ctl          (chain_ctl),
    .head_word          (head_word)
  );

  sle_chain u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .head_word (head_word)
  );

endmodule

FILE: hw/rtl/sle_checker.sv
`include "assert_macros.svh"

module sle_checker import sle_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [STATUS_W-1:0]      out_status,
  input logic signed [DATA_W-1:0] out_data,
  input logic [POS_W-1:0]         out_found_position,
  input logic [POS_W-1:0]         out_count,
  input logic                     out_empty_res
);

  `ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid,
               out_empty_res == (out_count == '0), "empty flag disagrees with count")

  `ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL),
               out_count == POS_W'(CAPACITY), "full status with spare room")

  `ASSERT_IMPL(a_miss_no_data, clk, rst_n, out_valid && (out_status == ST_NOTFOUND),
               out_data == '0, "miss returned data")

  `ASSERT_IMPL(a_match_in_list, clk, rst_n, out_valid,
               out_found_position <= out_count, "match position beyond list end")

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
               out_valid && $stable(out_data) && $stable(out_count), "stalled result changed")

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (.*);
